// File: src/assert_macros.svh
// assertion macros for the rotation matrix block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");
`define ASSERT_NORST(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: src/e2r_pkg.sv
// ----------------------------------------------------------------------------
// e2r_pkg
// types, constants and helpers for the euler to rotation matrix block
// ----------------------------------------------------------------------------
package e2r_pkg;
	localparam int AngleW = 16;
	localparam int ElemW = 16;
	localparam int TrigW = 16;
	localparam int Lanes = 3;
	localparam int PhaseGain = 83443;
	localparam logic [30:0] SinC1 = 31'd1686629713;
	localparam logic [30:0] SinC3 = 31'd693598668;
	localparam logic [30:0] SinC5 = 31'd85569304;
	localparam logic [30:0] SinC7 = 31'd5026995;
	localparam logic [30:0] SinC9 = 31'd172272;
	localparam int TrigDepth = 9;
	localparam int MrgDepth = 4;

	typedef logic signed [AngleW-1:0] angle_t;
	typedef logic signed [ElemW-1:0] elem_t;
	typedef logic signed [TrigW-1:0] trig_t;

	typedef struct packed {
		angle_t yaw_angle;
		angle_t pitch_angle;
		angle_t roll_angle;
	} in_word_t;

	typedef struct packed {
		elem_t m00; elem_t m01; elem_t m02;
		elem_t m10; elem_t m11; elem_t m12;
		elem_t m20; elem_t m21; elem_t m22;
	} out_word_t;

	typedef struct packed {
		trig_t s;
		trig_t c;
	} sc_t;

	// clamp to plus or minus one in q1.14
	function automatic elem_t clamp_unit(input logic signed [47:0] v);
		if (v > 48'sd16384) clamp_unit = 16'sd16384;
		else if (v < -48'sd16384) clamp_unit = -16'sd16384;
		else clamp_unit = v[15:0];
	endfunction
endpackage

// File: src/e2r_stream_if.sv
// ----------------------------------------------------------------------------
// e2r_stream_if
// valid/ready channel carrying one word
// ----------------------------------------------------------------------------
interface e2r_stream_if #(parameter int W = 48);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: src/euler_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// euler_to_rotation_matrix
// z-y-x euler angles to direction cosine matrix, fixed point
// ----------------------------------------------------------------------------
// in carries a word of yaw, pitch and roll angles (q2.13), out carries a word
// of the nine matrix elements (q1.14). one word is taken each cycle unless the
// output stalls; three sine/cosine lanes work side by side and a merge pipeline
// forms the products. the lanes register the phase, the quarter-wave arguments
// and the horner chain of the quarter-wave polynomial, and the merge registers
// the products and the matrix word. the whole pipeline advances as one: when
// the receiver stalls with a word waiting at the output, the pipeline holds and
// in.ready follows out.ready or an empty output. reset clears the valid bits
// only, so no word is shown after reset until one has gone through.
module euler_to_rotation_matrix (
	input  logic clk,
	input  logic arst_n,
	e2r_stream_if.sink in,
	e2r_stream_if.source out
);
	localparam int Depth = e2r_pkg::TrigDepth + e2r_pkg::MrgDepth;
	logic [Depth-1:0] vld_q;
	logic en;
	e2r_pkg::in_word_t iw;
	e2r_pkg::sc_t ysc, psc, rsc;
	e2r_pkg::out_word_t ow;

	assign en = out.ready || !vld_q[Depth-1];
	assign in.ready = en;
	assign out.valid = vld_q[Depth-1];
	assign iw = in.data;
	assign out.data = ow;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[Depth-2:0], in.valid};
	end

	e2r_trig_lane u_yaw (.clk(clk), .en(en), .angle(iw.yaw_angle), .sc(ysc));
	e2r_trig_lane u_pitch (.clk(clk), .en(en), .angle(iw.pitch_angle), .sc(psc));
	e2r_trig_lane u_roll (.clk(clk), .en(en), .angle(iw.roll_angle), .sc(rsc));
	e2r_merge u_merge (.clk(clk), .en(en), .yaw_sc(ysc), .pitch_sc(psc), .roll_sc(rsc),
		.word(ow));

`include "assert_macros.svh"
	`ASSERT_IMPL(a_hold, clk, arst_n, out.valid && !out.ready |=> out.valid && $stable(out.data))
	`ASSERT_IMPL(a_ready, clk, arst_n, !out.valid |-> in.ready)
	`ASSERT_IMPL(a_flow, clk, arst_n, in.valid && in.ready |=> vld_q[0])
endmodule

// File: src/e2r_trig_lane.sv
// ----------------------------------------------------------------------------
// e2r_trig_lane
// pipelined sine and cosine of one q2.13 angle
// ----------------------------------------------------------------------------
module e2r_trig_lane (
	input  logic clk,
	input  logic en,
	input  e2r_pkg::angle_t angle,
	output e2r_pkg::sc_t sc
);
	// stage 1: phase product
	logic signed [33:0] prod_s1;
	// stage 2: phase, sin and cos arguments
	logic [14:0] xs_s2, xc_s2;
	logic ns_s2, nc_s2;
	// stage 3..: polynomial
	logic [14:0] xs_s3, xc_s3;
	logic [14:0] x2s_s3, x2c_s3;
	logic ns_s3, nc_s3;
	logic [14:0] xs_p [4:7];
	logic [14:0] xc_p [4:7];
	logic [14:0] x2s_p [4:6];
	logic [14:0] x2c_p [4:6];
	logic [30:0] ts_p [4:7];
	logic [30:0] tc_p [4:7];
	logic ns_p [4:8];
	logic nc_p [4:8];
	logic [45:0] rs_s8, rc_s8;
	logic [15:0] p_c;
	logic [15:0] pc_c;
	logic [33:0] rnd_c;

	assign rnd_c = prod_s1 + 34'sd32768;
	assign p_c = rnd_c[31:16];
	assign pc_c = p_c + 16'd16384;

	function automatic logic [14:0] qarg(input logic [15:0] p);
		qarg = p[14] ? (15'd16384 - {1'b0, p[13:0]}) : {1'b0, p[13:0]};
	endfunction

	function automatic logic [30:0] hstep(input logic [30:0] c, input logic [14:0] x2,
		input logic [30:0] t);
		logic [45:0] m;
		m = {31'd0, x2} * {15'd0, t};
		hstep = c - m[44:14];
	endfunction

	function automatic e2r_pkg::trig_t qfin(input logic [45:0] r, input logic n);
		logic [45:0] u;
		logic [15:0] v;
		u = (r >> 14) + 46'd32768;
		v = (u[45:16] > 30'd16384) ? 16'd16384 : u[31:16];
		qfin = n ? -$signed(v) : $signed(v);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 34'(angle) * 34'sd83443;
			xs_s2 <= qarg(p_c);
			xc_s2 <= qarg(pc_c);
			ns_s2 <= p_c[15];
			nc_s2 <= pc_c[15];
			xs_s3 <= xs_s2;
			xc_s3 <= xc_s2;
			x2s_s3 <= 15'((30'(xs_s2) * 30'(xs_s2)) >> 14);
			x2c_s3 <= 15'((30'(xc_s2) * 30'(xc_s2)) >> 14);
			ns_s3 <= ns_s2;
			nc_s3 <= nc_s2;
			xs_p[4] <= xs_s3; xc_p[4] <= xc_s3;
			x2s_p[4] <= x2s_s3; x2c_p[4] <= x2c_s3;
			ns_p[4] <= ns_s3; nc_p[4] <= nc_s3;
			ts_p[4] <= hstep(e2r_pkg::SinC7, x2s_s3, e2r_pkg::SinC9);
			tc_p[4] <= hstep(e2r_pkg::SinC7, x2c_s3, e2r_pkg::SinC9);
			for (int i = 5; i <= 7; i++) begin
				xs_p[i] <= xs_p[i-1]; xc_p[i] <= xc_p[i-1];
				ns_p[i] <= ns_p[i-1]; nc_p[i] <= nc_p[i-1];
			end
			x2s_p[5] <= x2s_p[4]; x2c_p[5] <= x2c_p[4];
			x2s_p[6] <= x2s_p[5]; x2c_p[6] <= x2c_p[5];
			ts_p[5] <= hstep(e2r_pkg::SinC5, x2s_p[4], ts_p[4]);
			tc_p[5] <= hstep(e2r_pkg::SinC5, x2c_p[4], tc_p[4]);
			ts_p[6] <= hstep(e2r_pkg::SinC3, x2s_p[5], ts_p[5]);
			tc_p[6] <= hstep(e2r_pkg::SinC3, x2c_p[5], tc_p[5]);
			ts_p[7] <= hstep(e2r_pkg::SinC1, x2s_p[6], ts_p[6]);
			tc_p[7] <= hstep(e2r_pkg::SinC1, x2c_p[6], tc_p[6]);
			ns_p[8] <= ns_p[7]; nc_p[8] <= nc_p[7];
			rs_s8 <= {31'd0, xs_p[7]} * {15'd0, ts_p[7]};
			rc_s8 <= {31'd0, xc_p[7]} * {15'd0, tc_p[7]};
			sc.s <= qfin(rs_s8, ns_p[8]);
			sc.c <= qfin(rc_s8, nc_p[8]);
		end
	end
endmodule

// File: src/e2r_merge.sv
// ----------------------------------------------------------------------------
// e2r_merge
// combines the three lanes' sine and cosine into the nine matrix elements
// ----------------------------------------------------------------------------
module e2r_merge (
	input  logic clk,
	input  logic en,
	input  e2r_pkg::sc_t yaw_sc,
	input  e2r_pkg::sc_t pitch_sc,
	input  e2r_pkg::sc_t roll_sc,
	output e2r_pkg::out_word_t word
);
	typedef logic signed [31:0] p2_t;
	typedef logic signed [47:0] p3_t;
	p2_t cpcy_s1, cpsy_s1, srcp_s1, crcp_s1, crsy_s1, crcy_s1, srsy_s1, srcy_s1;
	p2_t srsp_s1, crsp_s1;
	e2r_pkg::trig_t sp_s1, sy_s1, cy_s1;
	p3_t a_s2, b_s2, c_s2, d_s2;
	p2_t cpcy_s2, cpsy_s2, srcp_s2, crcp_s2, crsy_s2, crcy_s2, srsy_s2, srcy_s2;
	e2r_pkg::trig_t sp_s2;
	p3_t t10_s3, t11_s3, t20_s3, t21_s3;
	p2_t cpcy_s3, cpsy_s3, srcp_s3, crcp_s3;
	e2r_pkg::trig_t sp_s3;

	function automatic e2r_pkg::elem_t q28(input p2_t v);
		logic signed [47:0] w;
		w = (48'(v) + 48'sd8192) >>> 14;
		q28 = e2r_pkg::clamp_unit(w);
	endfunction

	function automatic e2r_pkg::elem_t q42(input p3_t v);
		logic signed [47:0] w;
		w = (v + 48'sd134217728) >>> 28;
		q42 = e2r_pkg::clamp_unit(w);
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			cpcy_s1 <= pitch_sc.c * yaw_sc.c;
			cpsy_s1 <= pitch_sc.c * yaw_sc.s;
			srcp_s1 <= roll_sc.s * pitch_sc.c;
			crcp_s1 <= roll_sc.c * pitch_sc.c;
			crsy_s1 <= roll_sc.c * yaw_sc.s;
			crcy_s1 <= roll_sc.c * yaw_sc.c;
			srsy_s1 <= roll_sc.s * yaw_sc.s;
			srcy_s1 <= roll_sc.s * yaw_sc.c;
			srsp_s1 <= roll_sc.s * pitch_sc.s;
			crsp_s1 <= roll_sc.c * pitch_sc.s;
			sp_s1 <= pitch_sc.s;
			sy_s1 <= yaw_sc.s;
			cy_s1 <= yaw_sc.c;
			a_s2 <= 48'(srsp_s1) * 48'(cy_s1);
			b_s2 <= 48'(srsp_s1) * 48'(sy_s1);
			c_s2 <= 48'(crsp_s1) * 48'(cy_s1);
			d_s2 <= 48'(crsp_s1) * 48'(sy_s1);
			cpcy_s2 <= cpcy_s1; cpsy_s2 <= cpsy_s1; srcp_s2 <= srcp_s1; crcp_s2 <= crcp_s1;
			crsy_s2 <= crsy_s1; crcy_s2 <= crcy_s1; srsy_s2 <= srsy_s1; srcy_s2 <= srcy_s1;
			sp_s2 <= sp_s1;
			t10_s3 <= a_s2 - (48'(crsy_s2) <<< 14);
			t11_s3 <= b_s2 + (48'(crcy_s2) <<< 14);
			t20_s3 <= c_s2 + (48'(srsy_s2) <<< 14);
			t21_s3 <= d_s2 - (48'(srcy_s2) <<< 14);
			cpcy_s3 <= cpcy_s2; cpsy_s3 <= cpsy_s2; srcp_s3 <= srcp_s2; crcp_s3 <= crcp_s2;
			sp_s3 <= sp_s2;
			word.m00 <= q28(cpcy_s3);
			word.m01 <= q28(cpsy_s3);
			word.m02 <= e2r_pkg::clamp_unit(-48'(sp_s3));
			word.m10 <= q42(t10_s3);
			word.m11 <= q42(t11_s3);
			word.m12 <= q28(srcp_s3);
			word.m20 <= q42(t20_s3);
			word.m21 <= q42(t21_s3);
			word.m22 <= q28(crcp_s3);
		end
	end
endmodule

// File: tb/tb_euler_to_rotation_matrix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_rotation_matrix
// checks the euler angle to rotation matrix block against a fixed-point
// predictor: directed extreme and special angles, then random angle sets,
// with random idling on both channels, a back-to-back run and a drain pause
// ----------------------------------------------------------------------------
module tb_euler_to_rotation_matrix;
	localparam int Latency = 13;
	localparam longint CycleLimit = 400000;

	logic clk;
	logic arst_n;
	int failures;
	longint cycles;
	bit quiet_sink;
	bit quiet_source;

	e2r_pkg::out_word_t matrix_queue[$];

	e2r_stream_if #(.W($bits(e2r_pkg::in_word_t))) in_if();
	e2r_stream_if #(.W($bits(e2r_pkg::out_word_t))) out_if();

	euler_to_rotation_matrix uut (
		.clk(clk),
		.arst_n(arst_n),
		.in(in_if.sink),
		.out(out_if.source)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint rnd_shift(longint v, int sh);
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint unit_clamp(longint v);
		if (v > 16384) return 16384;
		if (v < -16384) return -16384;
		return v;
	endfunction

	function automatic longint quarter_wave(longint x);
		longint x2, t, r;
		x2 = (x * x) >>> 14;
		t = 172272;
		t = 5026995 - ((x2 * t) >>> 14);
		t = 85569304 - ((x2 * t) >>> 14);
		t = 693598668 - ((x2 * t) >>> 14);
		t = 1686629713 - ((x2 * t) >>> 14);
		r = (x * t) >>> 14;
		r = (r + (1 << 15)) >>> 16;
		if (r > 16384) r = 16384;
		return r;
	endfunction

	function automatic longint phase_sine(logic [15:0] p);
		longint s;
		s = p[14] ? quarter_wave(16384 - longint'(p[13:0])) : quarter_wave(longint'(p[13:0]));
		return p[15] ? -s : s;
	endfunction

	function automatic void angle_trig(e2r_pkg::angle_t a, output longint s,
		output longint c);
		longint ph;
		logic [15:0] p;
		ph = rnd_shift(longint'(a) * 83443, 16);
		p = ph[15:0];
		s = phase_sine(p);
		c = phase_sine(p + 16'd16384);
	endfunction

	function automatic e2r_pkg::elem_t q28(longint v);
		longint r;
		r = unit_clamp(rnd_shift(v, 14));
		return r[15:0];
	endfunction

	function automatic e2r_pkg::elem_t q42(longint v);
		longint r;
		r = unit_clamp(rnd_shift(v, 28));
		return r[15:0];
	endfunction

	function automatic e2r_pkg::out_word_t dcm_predict(e2r_pkg::in_word_t w);
		longint sy_, cy_, sp_, cp_, sr_, cr_, t;
		e2r_pkg::out_word_t m;
		angle_trig(w.yaw_angle, sy_, cy_);
		angle_trig(w.pitch_angle, sp_, cp_);
		angle_trig(w.roll_angle, sr_, cr_);
		m.m00 = q28(cp_ * cy_);
		m.m01 = q28(cp_ * sy_);
		t = unit_clamp(-sp_);
		m.m02 = t[15:0];
		m.m10 = q42(sr_ * sp_ * cy_ - cr_ * sy_ * 16384);
		m.m11 = q42(sr_ * sp_ * sy_ + cr_ * cy_ * 16384);
		m.m12 = q28(sr_ * cp_);
		m.m20 = q42(cr_ * sp_ * cy_ + sr_ * sy_ * 16384);
		m.m21 = q42(cr_ * sp_ * sy_ - sr_ * cy_ * 16384);
		m.m22 = q28(cr_ * cp_);
		return m;
	endfunction

	task automatic send_angles(e2r_pkg::angle_t yaw, e2r_pkg::angle_t pitch,
		e2r_pkg::angle_t roll);
		e2r_pkg::in_word_t w;
		w.yaw_angle = yaw;
		w.pitch_angle = pitch;
		w.roll_angle = roll;
		while (!quiet_source && $urandom_range(99) < 20) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.data <= w;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		matrix_queue.insert(matrix_queue.size(), dcm_predict(w));
	endtask

	task automatic wait_drain();
		in_if.valid <= 1'b0;
		while (matrix_queue.size() != 0) @(posedge clk);
		repeat (Latency + 4) @(posedge clk);
	endtask

	task automatic test_directed();
		e2r_pkg::angle_t v[8];
		v = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sd1, -16'sd1,
			16'sd12868, -16'sd12868, 16'sd25736};
		for (int i = 0; i < 8; i++) send_angles(v[i], v[(i + 3) % 8], v[(i + 5) % 8]);
		send_angles(16'sh7fff, 16'sh7fff, 16'sh7fff);
		send_angles(-16'sh8000, -16'sh8000, -16'sh8000);
		send_angles(16'sd0, 16'sd12868, 16'sd0);
		send_angles(16'sd0, -16'sd12868, 16'sd6434);
		send_angles(16'sd6434, 16'sd6434, 16'sd6434);
		send_angles(16'sh5555, -16'sh5556, 16'sh2aaa);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_angles(16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	task automatic test_back_to_back(int n);
		quiet_source = 1'b1;
		quiet_sink = 1'b1;
		for (int i = 0; i < n; i++)
			send_angles(16'($urandom), 16'($urandom), 16'($urandom));
		quiet_source = 1'b0;
		quiet_sink = 1'b0;
	endtask

	task automatic test_drain_pause();
		test_random(20);
		wait_drain();
		test_random(20);
	endtask

	always @(posedge clk) begin
		if (arst_n) out_if.ready <= quiet_sink || ($urandom_range(99) >= 20);
	end

	always @(posedge clk) begin
		e2r_pkg::out_word_t exp_m;
		if (arst_n && out_if.valid && out_if.ready) begin
			if (matrix_queue.size() == 0) begin
				$display("%0t: unexpected word %h", $time, out_if.data);
				failures++;
			end else begin
				exp_m = matrix_queue.pop_front();
				if (out_if.data !== exp_m) begin
					$display("%0t: mismatch expected %h actual %h", $time, exp_m, out_if.data);
					failures++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("** euler_to_rotation_matrix: FAILED **");
			$finish;
		end
	end

	initial begin
		failures = 0;
		cycles = 0;
		quiet_sink = 1'b0;
		quiet_source = 1'b0;
		arst_n = 1'b0;
		in_if.valid = 1'b0;
		in_if.data = '0;
		out_if.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(500);
		test_back_to_back(200);
		test_drain_pause();
		test_random(340);
		wait_drain();
		if (failures == 0 && matrix_queue.size() == 0) begin
			$display("** euler_to_rotation_matrix: PASSED **");
		end else begin
			$display("** euler_to_rotation_matrix: FAILED **");
		end
		$finish;
	end
endmodule
